/* rtl/itb_pkg.sv */
// ----------------------------------------------------------------------------
// itb_pkg
// Shared sizes, constants and interface types of the block threshold
// binarizer: group length, fixed-point format and divider request/response.
// ----------------------------------------------------------------------------
package itb_pkg;

    // group length and fixed-point fraction of the threshold
    localparam int BLOCK_LEN = 9;
    localparam int FRAC_BITS = 4;

    // pixel and derived widths
    localparam int PIX_W  = 8;
    localparam int ITER_W = 6;
    localparam int CNT_W  = $clog2(BLOCK_LEN + 1);
    localparam int ADDR_W = $clog2(BLOCK_LEN);
    localparam int SUM_W  = $clog2(BLOCK_LEN * 255 + 1);
    localparam int T_W    = PIX_W + FRAC_BITS;
    localparam int NUMI_W = SUM_W + FRAC_BITS;

    // rounding divider internals: numerator 2*num+den, divisor 2*den
    localparam int DIV_N_W = NUMI_W + 2;
    localparam int DIV_D_W = CNT_W + 1;
    localparam int DCNT_W  = $clog2(DIV_N_W + 1);

    // rounding offset of the threshold, zero without fraction bits
    localparam int HALF = (1 << FRAC_BITS) >> 1;

    // reset value of the round limit
    localparam logic [ITER_W-1:0] MAX_ITERS_RST = ITER_W'(16);

    // divider request
    typedef struct packed {
        logic              start;
        logic [NUMI_W-1:0] num;
        logic [CNT_W-1:0]  den;
    } div_req_t;

    // divider response
    typedef struct packed {
        logic           busy;
        logic           done;
        logic [T_W-1:0] quo;
    } div_rsp_t;

endpackage

/* rtl/itb_ram.sv */
// ----------------------------------------------------------------------------
// itb_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module itb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/itb_rdiv.sv */
// ----------------------------------------------------------------------------
// itb_rdiv
// Bit-serial restoring divider returning round-half-up of num / den,
// computed as (2*num + den) / (2*den), one quotient bit per cycle.
// ----------------------------------------------------------------------------
module itb_rdiv (
    input  logic              aclk,
    input  logic              aresetn,
    input  itb_pkg::div_req_t req,
    output itb_pkg::div_rsp_t rsp
);

    logic [itb_pkg::DIV_N_W-1:0] quo_reg, quo_next;
    logic [itb_pkg::DIV_D_W-1:0] den_reg, den_next;
    logic [itb_pkg::DIV_D_W-1:0] rem_reg, rem_next;
    logic [itb_pkg::DCNT_W-1:0]  cnt_reg, cnt_next;
    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [itb_pkg::DIV_D_W:0]   rem_sh;
    logic                        ge;

    // one restoring step
    assign rem_sh = {rem_reg, quo_reg[itb_pkg::DIV_N_W-1]};
    assign ge     = rem_sh >= {1'b0, den_reg};

    always_comb begin
        quo_next  = quo_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start && !busy_reg) begin
            quo_next  = itb_pkg::DIV_N_W'({req.num, 1'b0})
                      + itb_pkg::DIV_N_W'(req.den);
            den_next  = {req.den, 1'b0};
            rem_next  = '0;
            cnt_next  = itb_pkg::DCNT_W'(itb_pkg::DIV_N_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (ge) begin
                rem_next = itb_pkg::DIV_D_W'(rem_sh - {1'b0, den_reg});
            end else begin
                rem_next = rem_sh[itb_pkg::DIV_D_W-1:0];
            end
            quo_next = {quo_reg[itb_pkg::DIV_N_W-2:0], ge};
            cnt_next = cnt_reg - itb_pkg::DCNT_W'(1);
            if (cnt_reg == itb_pkg::DCNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control under reset, datapath free running
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg[itb_pkg::T_W-1:0];

endmodule

/* rtl/block_iterative_threshold_binarizer_core.sv */
// Flow: a group closes on its last pixel; the group mean goes through the divider,
// each refinement round is a buffer scan plus divider passes for the non-empty
// class means (one quotient bit per cycle) and an update, then results come out.
// Throughput: one pixel per cycle while a group fills; no pixel is taken while
// a closed group is refined and emitted.
// Reset: synchronous active low; clears fill state and sets max_iters to 16.
// ----------------------------------------------------------------------------
// block_iterative_threshold_binarizer_core
// Gathers pixels into groups in a sample RAM, refines an isodata threshold
// per group by repeated passes over the RAM and emits one bit per pixel.
// ----------------------------------------------------------------------------
module block_iterative_threshold_binarizer_core (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [itb_pkg::ITER_W-1:0]   cfg_wr_data,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [itb_pkg::PIX_W-1:0]    s_pixel,
    input  logic                         s_end_of_line,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_bit_res,
    output logic [itb_pkg::PIX_W-1:0]    m_threshold,
    output logic                         m_last
);

    typedef enum logic [3:0] {
        ST_FILL, ST_MEAN, ST_MEAN_WAIT, ST_SCAN, ST_HI, ST_HI_WAIT,
        ST_LO, ST_LO_WAIT, ST_UPDATE, ST_EMIT_RD, ST_EMIT_LD, ST_EMIT_OUT
    } state_t;

    state_t                     state_reg, state_next;
    logic [itb_pkg::ITER_W-1:0] max_iters_reg, max_iters_next;
    logic [itb_pkg::CNT_W-1:0]  fill_reg, fill_next;
    logic [itb_pkg::SUM_W-1:0]  sum_reg, sum_next;
    logic [itb_pkg::T_W-1:0]    t_reg, t_next;
    logic [itb_pkg::ITER_W-1:0] rnd_reg, rnd_next;
    logic [itb_pkg::CNT_W-1:0]  idx_reg, idx_next;
    logic                       pend_reg, pend_next;
    logic [itb_pkg::SUM_W-1:0]  shi_reg, shi_next, slo_reg, slo_next;
    logic [itb_pkg::CNT_W-1:0]  nhi_reg, nhi_next, nlo_reg, nlo_next;
    logic [itb_pkg::T_W-1:0]    mhi_reg, mhi_next, mlo_reg, mlo_next;
    logic [itb_pkg::PIX_W-1:0]  thr_reg, thr_next;
    logic                       m_valid_reg, m_valid_next;
    logic                       m_bit_reg, m_bit_next;
    logic                       m_last_reg, m_last_next;

    logic                       ram_we;
    logic [itb_pkg::ADDR_W-1:0] ram_raddr;
    logic [itb_pkg::PIX_W-1:0]  ram_rdata;
    itb_pkg::div_req_t          div_req;
    itb_pkg::div_rsp_t          div_rsp;

    logic                       in_acc;
    logic [itb_pkg::CNT_W-1:0]  fill_inc;
    logic [itb_pkg::ITER_W-1:0] rnd_lim;
    logic [itb_pkg::T_W-1:0]    mh, ml, tk;
    logic [itb_pkg::T_W:0]      tk_sum, thr_sum, thr_sh;
    logic                       above;

    // sample buffer
    itb_ram #(
        .WIDTH (itb_pkg::PIX_W),
        .DEPTH (itb_pkg::BLOCK_LEN)
    ) u_buf (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (fill_reg[itb_pkg::ADDR_W-1:0]),
        .wdata (s_pixel),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // shared rounding divider
    itb_rdiv u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign s_ready  = (state_reg == ST_FILL);
    assign in_acc   = s_valid && s_ready;
    assign ram_we   = in_acc;
    assign fill_inc = fill_reg + itb_pkg::CNT_W'(1);
    assign rnd_lim  = (max_iters_reg == '0) ? itb_pkg::ITER_W'(1) : max_iters_reg;

    // class split of the sample returned by the ram
    assign above = (itb_pkg::T_W'(ram_rdata) << itb_pkg::FRAC_BITS) > t_reg;

    // empty class takes the other class mean, then average the two
    assign mh      = (nhi_reg == '0) ? mlo_reg : mhi_reg;
    assign ml      = (nlo_reg == '0) ? mhi_reg : mlo_reg;
    assign tk_sum  = (itb_pkg::T_W+1)'(mh) + (itb_pkg::T_W+1)'(ml) + (itb_pkg::T_W+1)'(1);
    assign tk      = tk_sum[itb_pkg::T_W:1];
    assign thr_sum = (itb_pkg::T_W+1)'(tk) + (itb_pkg::T_W+1)'(itb_pkg::HALF);
    assign thr_sh  = thr_sum >> itb_pkg::FRAC_BITS;

    // read address of the sample buffer
    always_comb begin
        case (state_reg)
            ST_SCAN:    ram_raddr = idx_reg[itb_pkg::ADDR_W-1:0];
            ST_EMIT_RD: ram_raddr = idx_reg[itb_pkg::ADDR_W-1:0];
            default:    ram_raddr = '0;
        endcase
    end

    // divider requests: group mean, then upper and lower class means
    always_comb begin
        div_req.start = 1'b0;
        div_req.num   = itb_pkg::NUMI_W'(sum_reg) << itb_pkg::FRAC_BITS;
        div_req.den   = fill_reg;
        case (state_reg)
            ST_MEAN: begin
                div_req.start = 1'b1;
            end
            ST_HI: begin
                div_req.start = (nhi_reg != '0);
                div_req.num   = itb_pkg::NUMI_W'(shi_reg) << itb_pkg::FRAC_BITS;
                div_req.den   = nhi_reg;
            end
            ST_LO: begin
                div_req.start = (nlo_reg != '0);
                div_req.num   = itb_pkg::NUMI_W'(slo_reg) << itb_pkg::FRAC_BITS;
                div_req.den   = nlo_reg;
            end
            default: begin
                div_req.start = 1'b0;
            end
        endcase
    end

    // sequencer next state
    always_comb begin
        state_next     = state_reg;
        max_iters_next = cfg_wr_en ? cfg_wr_data : max_iters_reg;
        fill_next      = fill_reg;
        sum_next       = sum_reg;
        t_next         = t_reg;
        rnd_next       = rnd_reg;
        idx_next       = idx_reg;
        pend_next      = 1'b0;
        shi_next       = shi_reg;
        slo_next       = slo_reg;
        nhi_next       = nhi_reg;
        nlo_next       = nlo_reg;
        mhi_next       = mhi_reg;
        mlo_next       = mlo_reg;
        thr_next       = thr_reg;
        m_valid_next   = m_valid_reg;
        m_bit_next     = m_bit_reg;
        m_last_next    = m_last_reg;

        case (state_reg)
            // collect pixels until the group is full or the line ends
            ST_FILL: begin
                if (in_acc) begin
                    fill_next = fill_inc;
                    sum_next  = sum_reg + itb_pkg::SUM_W'(s_pixel);
                    if (fill_inc == itb_pkg::CNT_W'(itb_pkg::BLOCK_LEN) || s_end_of_line) begin
                        state_next = ST_MEAN;
                    end
                end
            end
            ST_MEAN: begin
                state_next = ST_MEAN_WAIT;
            end
            // initial threshold is the group mean
            ST_MEAN_WAIT: begin
                if (div_rsp.done) begin
                    t_next     = div_rsp.quo;
                    rnd_next   = '0;
                    idx_next   = '0;
                    shi_next   = '0;
                    slo_next   = '0;
                    nhi_next   = '0;
                    nlo_next   = '0;
                    state_next = ST_SCAN;
                end
            end
            // one pass over the buffer, data arrives in the cycle after the address
            ST_SCAN: begin
                if (idx_reg != fill_reg) begin
                    idx_next  = idx_reg + itb_pkg::CNT_W'(1);
                    pend_next = 1'b1;
                end
                if (pend_reg) begin
                    if (above) begin
                        shi_next = shi_reg + itb_pkg::SUM_W'(ram_rdata);
                        nhi_next = nhi_reg + itb_pkg::CNT_W'(1);
                    end else begin
                        slo_next = slo_reg + itb_pkg::SUM_W'(ram_rdata);
                        nlo_next = nlo_reg + itb_pkg::CNT_W'(1);
                    end
                end else if (idx_reg == fill_reg) begin
                    state_next = ST_HI;
                end
            end
            ST_HI: begin
                state_next = (nhi_reg != '0) ? ST_HI_WAIT : ST_LO;
            end
            ST_HI_WAIT: begin
                if (div_rsp.done) begin
                    mhi_next   = div_rsp.quo;
                    state_next = ST_LO;
                end
            end
            ST_LO: begin
                state_next = (nlo_reg != '0) ? ST_LO_WAIT : ST_UPDATE;
            end
            ST_LO_WAIT: begin
                if (div_rsp.done) begin
                    mlo_next   = div_rsp.quo;
                    state_next = ST_UPDATE;
                end
            end
            // new threshold; stop when settled or out of rounds
            ST_UPDATE: begin
                t_next = tk;
                if (tk == t_reg || itb_pkg::ITER_W'(rnd_reg + itb_pkg::ITER_W'(1)) == rnd_lim) begin
                    thr_next   = (thr_sh > (itb_pkg::T_W+1)'(255)) ? 8'hFF
                                                                   : thr_sh[itb_pkg::PIX_W-1:0];
                    idx_next   = '0;
                    state_next = ST_EMIT_RD;
                end else begin
                    rnd_next   = rnd_reg + itb_pkg::ITER_W'(1);
                    idx_next   = '0;
                    shi_next   = '0;
                    slo_next   = '0;
                    nhi_next   = '0;
                    nlo_next   = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_EMIT_RD: begin
                state_next = ST_EMIT_LD;
            end
            // load the output word
            ST_EMIT_LD: begin
                m_valid_next = 1'b1;
                m_bit_next   = (ram_rdata >= thr_reg);
                m_last_next  = (itb_pkg::CNT_W'(idx_reg + itb_pkg::CNT_W'(1)) == fill_reg);
                state_next   = ST_EMIT_OUT;
            end
            ST_EMIT_OUT: begin
                if (m_ready) begin
                    m_valid_next = 1'b0;
                    if (m_last_reg) begin
                        fill_next  = '0;
                        sum_next   = '0;
                        state_next = ST_FILL;
                    end else begin
                        idx_next   = idx_reg + itb_pkg::CNT_W'(1);
                        state_next = ST_EMIT_RD;
                    end
                end
            end
            default: begin
                state_next = ST_FILL;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_FILL;
            max_iters_reg <= itb_pkg::MAX_ITERS_RST;
            fill_reg      <= '0;
            sum_reg       <= '0;
            pend_reg      <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            max_iters_reg <= max_iters_next;
            fill_reg      <= fill_next;
            sum_reg       <= sum_next;
            pend_reg      <= pend_next;
            m_valid_reg   <= m_valid_next;
        end
        t_reg      <= t_next;
        rnd_reg    <= rnd_next;
        idx_reg    <= idx_next;
        shi_reg    <= shi_next;
        slo_reg    <= slo_next;
        nhi_reg    <= nhi_next;
        nlo_reg    <= nlo_next;
        mhi_reg    <= mhi_next;
        mlo_reg    <= mlo_next;
        thr_reg    <= thr_next;
        m_bit_reg  <= m_bit_next;
        m_last_reg <= m_last_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_bit_res   = m_bit_reg;
    assign m_threshold = thr_reg;
    assign m_last      = m_last_reg;

`ifndef SYNTHESIS
    // output word only presented while emitting
    a_valid_in_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (state_reg == ST_EMIT_OUT))
        else $error("result word outside emit phase");

    // fill count stays within the group length
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= itb_pkg::CNT_W'(itb_pkg::BLOCK_LEN))
        else $error("fill count beyond group length");

    // divider finishes only while the sequencer waits for it
    a_div_done_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> (state_reg == ST_MEAN_WAIT || state_reg == ST_HI_WAIT
                          || state_reg == ST_LO_WAIT))
        else $error("divider result not expected");

    // divider never started while busy
    a_div_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

    // taking the last word reopens the input with an empty group
    a_last_reopens: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_last) |=> (s_ready && fill_reg == '0))
        else $error("input not reopened after last word");
`endif

endmodule
